// ===== rtl/bakf_pkg.sv =====
// Package for the boot argument key finder.
// Holds the sizes, the scan mode codes, the delimiter check and the result struct.
// No dependencies; every other file refers to it by scoped names.
package bakf_pkg;

	localparam int KEY_MAX = 16;
	localparam int KEY_IDX_BITS = $clog2(KEY_MAX);
	localparam int KEY_LEN_BITS = $clog2(KEY_MAX + 1);
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_INDEX_BITS = 2;
	localparam int KEY_CFG_LEN_BITS = 5;
	localparam int POSITION_BITS = 16;
	localparam int FIELD_BITS = 16;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [7:0] CHAR_EQUALS = 8'h3D;

	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_LOW = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_LENGTH = 2'd2;

	typedef enum logic [1:0] {
		MODE_BETWEEN = 2'd0,
		MODE_KEY = 2'd1,
		MODE_SKIP = 2'd2,
		MODE_VALUE = 2'd3
	} scan_mode_t;

	typedef struct packed {
		logic found;
		logic has_value;
		logic [FIELD_BITS-1:0] value_offset;
		logic [FIELD_BITS-1:0] value_length;
		logic overflow;
	} result_t;

	function automatic logic is_delim(input logic [7:0] c);
		is_delim = (c == 8'h00) || (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

endpackage

// ===== rtl/bakf_line_scanner.sv =====
// Per-line scan state and its next-state logic for the key finder.
// Advances by one byte per step and forms the result for a final byte.
// Depends on bakf_pkg.
module bakf_line_scanner (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [7:0] text_byte,
	input  logic final_byte,
	input  logic [bakf_pkg::KEY_MAX-1:0][7:0] key_bytes,
	input  logic [bakf_pkg::KEY_LEN_BITS-1:0] key_len,
	output bakf_pkg::result_t result
);

	bakf_pkg::scan_mode_t mode_q, mode_d, mode_a;
	logic [bakf_pkg::KEY_LEN_BITS-1:0] idx_q, idx_d, idx_a;
	logic [bakf_pkg::POSITION_BITS-1:0] pos_q, pos_inc;
	logic [bakf_pkg::POSITION_BITS-1:0] offset_q, offset_d;
	logic [bakf_pkg::POSITION_BITS-1:0] length_q, length_d;
	logic found_q, found_d, has_value_q, has_value_d, ov_q, ov_d;
	logic delim, pos_max;
	logic [7:0] key_byte;

	always_comb begin
		delim = bakf_pkg::is_delim(text_byte);
		pos_max = (pos_q == bakf_pkg::POS_MAX);
		pos_inc = pos_max ? bakf_pkg::POS_MAX : pos_q + 1'b1;
		ov_d = ov_q | pos_max;
		found_d = found_q;
		has_value_d = has_value_q;
		offset_d = offset_q;
		length_d = length_q;
		if ((mode_q == bakf_pkg::MODE_BETWEEN) && !delim) begin
			mode_a = bakf_pkg::MODE_KEY;
			idx_a = '0;
		end else begin
			mode_a = mode_q;
			idx_a = idx_q;
		end
		mode_d = mode_a;
		idx_d = idx_a;
		key_byte = key_bytes[idx_a[bakf_pkg::KEY_IDX_BITS-1:0]];
		case (mode_a)
			bakf_pkg::MODE_KEY: begin
				if (idx_a < key_len) begin
					if (delim) begin
						mode_d = bakf_pkg::MODE_BETWEEN;
					end else if (text_byte == key_byte) begin
						idx_d = idx_a + 1'b1;
					end else begin
						mode_d = bakf_pkg::MODE_SKIP;
					end
				end else if (delim) begin
					found_d = 1'b1;
					has_value_d = 1'b0;
					offset_d = pos_q;
					length_d = '0;
					mode_d = bakf_pkg::MODE_BETWEEN;
				end else if (text_byte == bakf_pkg::CHAR_EQUALS) begin
					found_d = 1'b1;
					has_value_d = 1'b1;
					offset_d = pos_inc;
					length_d = '0;
					mode_d = bakf_pkg::MODE_VALUE;
				end else begin
					mode_d = bakf_pkg::MODE_SKIP;
				end
			end
			bakf_pkg::MODE_SKIP: begin
				if (delim) begin
					mode_d = bakf_pkg::MODE_BETWEEN;
				end
			end
			bakf_pkg::MODE_VALUE: begin
				if (delim) begin
					mode_d = bakf_pkg::MODE_BETWEEN;
				end else if (length_q == bakf_pkg::POS_MAX) begin
					ov_d = 1'b1;
				end else begin
					length_d = length_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		// A key that runs up to the end of the line is a flag.
		if (final_byte && (mode_d == bakf_pkg::MODE_KEY) && (idx_d >= key_len)) begin
			found_d = 1'b1;
			has_value_d = 1'b0;
			offset_d = pos_inc;
			length_d = '0;
		end
		result.found = found_d;
		result.has_value = found_d & has_value_d;
		result.value_offset = found_d ? bakf_pkg::FIELD_BITS'(offset_d) : '0;
		result.value_length = found_d ? bakf_pkg::FIELD_BITS'(length_d) : '0;
		result.overflow = ov_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bakf_pkg::MODE_BETWEEN;
			idx_q <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			has_value_q <= 1'b0;
			offset_q <= '0;
			length_q <= '0;
			ov_q <= 1'b0;
		end else if (step) begin
			if (final_byte) begin
				mode_q <= bakf_pkg::MODE_BETWEEN;
				idx_q <= '0;
				pos_q <= '0;
				found_q <= 1'b0;
				has_value_q <= 1'b0;
				offset_q <= '0;
				length_q <= '0;
				ov_q <= 1'b0;
			end else begin
				mode_q <= mode_d;
				idx_q <= idx_d;
				pos_q <= pos_inc;
				found_q <= found_d;
				has_value_q <= has_value_d;
				offset_q <= offset_d;
				length_q <= length_d;
				ov_q <= ov_d;
			end
		end
	end

endmodule

// ===== rtl/boot_argument_key_finder_unit.sv =====
// Top level of the boot argument key finder.
// Holds the key registers, the input stage and the result register around the scanner.
// Depends on bakf_pkg and bakf_line_scanner.

// The block takes one command line byte per cycle while in_stall is low. A final byte
// passes the input stage and the line's result is then registered. The rate is set by the
// scan state update in the line scanner. A final byte waits in the input stage while the
// previous result is still stalled at the output, and only then does in_stall rise.
// Users must write key registers only while no line is in progress; no check enforces it.
module boot_argument_key_finder_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write_enable,
	input  logic [bakf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [bakf_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] text_byte,
	input  logic final_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic found,
	output logic has_value,
	output logic [bakf_pkg::FIELD_BITS-1:0] value_offset,
	output logic [bakf_pkg::FIELD_BITS-1:0] value_length,
	output logic overflow
);

	logic [bakf_pkg::CFG_DATA_BITS-1:0] key_low_q, key_high_q;
	logic [bakf_pkg::KEY_CFG_LEN_BITS-1:0] key_length_q;
	logic [bakf_pkg::KEY_LEN_BITS-1:0] key_len;
	logic [bakf_pkg::KEY_MAX-1:0][7:0] key_bytes;
	logic valid_s1, final_s1;
	logic [7:0] byte_s1;
	logic blocked, step;
	logic out_valid_q;
	bakf_pkg::result_t result, result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
			key_length_q <= bakf_pkg::KEY_CFG_LEN_BITS'(1);
		end else if (cfg_write_enable) begin
			case (cfg_index)
				bakf_pkg::REG_KEY_LOW: key_low_q <= cfg_data;
				bakf_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				bakf_pkg::REG_KEY_LENGTH: begin
					key_length_q <= cfg_data[bakf_pkg::KEY_CFG_LEN_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign key_bytes = {key_high_q, key_low_q};
	assign key_len = (key_length_q > bakf_pkg::KEY_CFG_LEN_BITS'(bakf_pkg::KEY_MAX)) ?
		bakf_pkg::KEY_LEN_BITS'(bakf_pkg::KEY_MAX) :
		bakf_pkg::KEY_LEN_BITS'(key_length_q);

	assign blocked = valid_s1 && final_s1 && out_valid_q && out_stall;
	assign step = valid_s1 && !blocked;
	assign in_stall = blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!blocked) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !blocked) begin
			byte_s1 <= text_byte;
			final_s1 <= final_byte;
		end
	end

	bakf_line_scanner u_scanner (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.text_byte(byte_s1),
		.final_byte(final_s1),
		.key_bytes(key_bytes),
		.key_len(key_len),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && final_s1) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign found = result_q.found;
	assign has_value = result_q.has_value;
	assign value_offset = result_q.value_offset;
	assign value_length = result_q.value_length;
	assign overflow = result_q.overflow;

endmodule

// ===== rtl/bakf_checker.sv =====
// Port-level checks for the boot argument key finder.
// Watches only the top-level ports and is attached by the bind statement below.
// Depends on bakf_pkg and boot_argument_key_finder_unit.
module bakf_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic out_valid,
	input  logic out_stall,
	input  logic found,
	input  logic has_value,
	input  logic [bakf_pkg::FIELD_BITS-1:0] value_offset,
	input  logic [bakf_pkg::FIELD_BITS-1:0] value_length,
	input  logic overflow
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(has_value)
			&& $stable(value_offset) && $stable(value_length) && $stable(overflow))
		else $error("Stalled result changed.");

	a_not_found_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> !has_value && (value_offset == '0) && (value_length == '0))
		else $error("Result without a match carries match fields.");

	a_value_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_value |-> found && (value_offset != '0))
		else $error("Value result has a zero offset.");

	a_flag_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_value |-> (value_length == '0))
		else $error("Flag result has a nonzero length.");

endmodule

bind boot_argument_key_finder_unit bakf_checker u_bakf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.found(found),
	.has_value(has_value),
	.value_offset(value_offset),
	.value_length(value_length),
	.overflow(overflow)
);

// ===== dv/tb_boot_argument_key_finder_unit.sv =====
`timescale 1ns / 1ps
// Testbench for boot_argument_key_finder_unit: feeds command lines one byte per request and
// checks each line's result against a scoreboard that tracks the key search itself.
// Depends on bakf_pkg and boot_argument_key_finder_unit.
module tb_boot_argument_key_finder_unit;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int POS_LIMIT = 65535;
	localparam int BYTES_PER_KEY = 150;
	localparam int KEYS_PER_PHASE = 4;
	localparam logic [7:0] DELIMS [7] = '{8'h00, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};

	class key_match_scoreboard;
		logic [63:0] key_low;
		logic [63:0] key_high;
		logic [4:0] key_len_reg;
		int unsigned position;
		bakf_pkg::scan_mode_t mode;
		int unsigned matched;
		logic hit;
		logic hit_value;
		int unsigned hit_offset;
		int unsigned hit_length;
		logic overflowed;
		bakf_pkg::result_t pending_results[$];
		int mismatch_count;

		function new();
			key_low = '0;
			key_high = '0;
			key_len_reg = 5'd1;
			mismatch_count = 0;
			clear_line();
		endfunction

		static function logic is_separator(logic [7:0] c);
			return (c == 8'h00) || (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
		endfunction

		function void clear_line();
			position = 0;
			mode = bakf_pkg::MODE_BETWEEN;
			matched = 0;
			hit = 1'b0;
			hit_value = 1'b0;
			hit_offset = 0;
			hit_length = 0;
			overflowed = 1'b0;
		endfunction

		function void write_register(logic [bakf_pkg::CFG_INDEX_BITS-1:0] idx, logic [63:0] data);
			case (idx)
				bakf_pkg::REG_KEY_LOW: key_low = data;
				bakf_pkg::REG_KEY_HIGH: key_high = data;
				bakf_pkg::REG_KEY_LENGTH: key_len_reg = data[4:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] key_at(int unsigned i);
			if (i < 8)
				return key_low[8*i +: 8];
			return key_high[8*(i-8) +: 8];
		endfunction

		function int unsigned bump(int unsigned v);
			if (v >= POS_LIMIT) begin
				overflowed = 1'b1;
				return POS_LIMIT;
			end
			return v + 1;
		endfunction

		function void note_match(logic with_value, int unsigned offset);
			hit = 1'b1;
			hit_value = with_value;
			hit_offset = offset;
			hit_length = 0;
		endfunction

		function void take_request(logic [7:0] c, logic last);
			logic d;
			int unsigned len;
			int unsigned pos;
			bakf_pkg::result_t r;
			d = is_separator(c);
			len = (key_len_reg > bakf_pkg::KEY_MAX) ? bakf_pkg::KEY_MAX : key_len_reg;
			pos = position;
			position = bump(position);
			if (mode == bakf_pkg::MODE_BETWEEN && !d) begin
				mode = bakf_pkg::MODE_KEY;
				matched = 0;
			end
			case (mode)
				bakf_pkg::MODE_KEY: begin
					if (matched < len) begin
						if (d)
							mode = bakf_pkg::MODE_BETWEEN;
						else if (c == key_at(matched))
							matched++;
						else
							mode = bakf_pkg::MODE_SKIP;
					end else if (d) begin
						note_match(1'b0, pos);
						mode = bakf_pkg::MODE_BETWEEN;
					end else if (c == bakf_pkg::CHAR_EQUALS) begin
						note_match(1'b1, bump(pos));
						mode = bakf_pkg::MODE_VALUE;
					end else begin
						mode = bakf_pkg::MODE_SKIP;
					end
				end
				bakf_pkg::MODE_SKIP: begin
					if (d)
						mode = bakf_pkg::MODE_BETWEEN;
				end
				bakf_pkg::MODE_VALUE: begin
					if (d)
						mode = bakf_pkg::MODE_BETWEEN;
					else
						hit_length = bump(hit_length);
				end
				default: ;
			endcase
			if (last) begin
				if (mode == bakf_pkg::MODE_KEY && matched >= len)
					note_match(1'b0, bump(pos));
				r.found = hit;
				r.has_value = hit & hit_value;
				r.value_offset = hit ? hit_offset[15:0] : '0;
				r.value_length = hit ? hit_length[15:0] : '0;
				r.overflow = overflowed;
				pending_results.push_back(r);
				clear_line();
			end
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				mismatch_count++;
			end
		endfunction

		function void check_result(bakf_pkg::result_t got);
			bakf_pkg::result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0b %0b %0d %0d %0b",
					$time, got.found, got.has_value, got.value_offset, got.value_length,
					got.overflow);
				mismatch_count++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("found", want.found, got.found);
			compare_field("has_value", want.has_value, got.has_value);
			compare_field("value_offset", want.value_offset, got.value_offset);
			compare_field("value_length", want.value_length, got.value_length);
			compare_field("overflow", want.overflow, got.overflow);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write_enable;
	logic [bakf_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [bakf_pkg::CFG_DATA_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [7:0] text_byte;
	logic final_byte;
	logic out_valid;
	logic out_stall;
	logic found;
	logic has_value;
	logic [bakf_pkg::FIELD_BITS-1:0] value_offset;
	logic [bakf_pkg::FIELD_BITS-1:0] value_length;
	logic overflow;

	key_match_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int eff_len = 1;
	int idle_cycles;
	logic [7:0] key_chars [bakf_pkg::KEY_MAX];

	boot_argument_key_finder_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_enable(cfg_write_enable),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.has_value(has_value),
		.value_offset(value_offset),
		.value_length(value_length),
		.overflow(overflow)
	);

	always #6 clk = ~clk;

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		final_byte <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_request(b, last);
		@(negedge clk);
	endtask

	task automatic send_line(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic send_text(input string s);
		logic [7:0] q[$];
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		send_line(q);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_register(input logic [bakf_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [63:0] data);
		cfg_write_enable <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write_enable <= 1'b0;
		sb.write_register(idx, data);
		@(negedge clk);
	endtask

	task automatic apply_key(input int len_reg);
		logic [63:0] low;
		logic [63:0] high;
		logic [63:0] len_word;
		for (int i = 0; i < 8; i++) begin
			low[8*i +: 8] = key_chars[i];
			high[8*i +: 8] = key_chars[i + 8];
		end
		len_word = {$urandom, $urandom};
		len_word[4:0] = 5'(len_reg);
		write_register(bakf_pkg::REG_KEY_LOW, low);
		write_register(bakf_pkg::REG_KEY_HIGH, high);
		write_register(bakf_pkg::REG_KEY_LENGTH, len_word);
		eff_len = (len_reg > bakf_pkg::KEY_MAX) ? bakf_pkg::KEY_MAX : len_reg;
	endtask

	task automatic load_key(input int kind);
		int len_reg;
		for (int i = 0; i < bakf_pkg::KEY_MAX; i++)
			key_chars[i] = 8'h61 + 8'($urandom_range(25));
		len_reg = $urandom_range(1, 6);
		case (kind)
			0: len_reg = 16;
			1: len_reg = 0;
			2: len_reg = 31;
			3: len_reg = 17;
			4: begin
				len_reg = 16;
				for (int i = 0; i < bakf_pkg::KEY_MAX; i++)
					key_chars[i] = 8'hFF;
			end
			5: begin
				len_reg = 3;
				key_chars[1] = DELIMS[$urandom_range(6)];
			end
			6: begin
				len_reg = 2;
				for (int i = 0; i < bakf_pkg::KEY_MAX; i++)
					key_chars[i] = 8'h00;
			end
			default: begin
				if ($urandom_range(3) == 0)
					key_chars[$urandom_range(len_reg - 1)] = 8'($urandom_range(255));
			end
		endcase
		apply_key(len_reg);
	endtask

	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (key_match_scoreboard::is_separator(b));
		return b;
	endfunction

	function automatic void push_key(ref logic [7:0] q[$], input int n);
		for (int i = 0; i < n; i++)
			q.push_back(key_chars[i]);
	endfunction

	function automatic void push_word(ref logic [7:0] q[$], input int n);
		repeat (n) q.push_back(word_byte());
	endfunction

	function automatic void build_line(ref logic [7:0] q[$]);
		logic [7:0] b;
		q.delete();
		if ($urandom_range(3) == 0)
			q.push_back(DELIMS[$urandom_range(6)]);
		for (int t = 0; t < $urandom_range(1, 5); t++) begin
			if (t != 0)
				repeat ($urandom_range(1, 2)) q.push_back(DELIMS[$urandom_range(6)]);
			case ($urandom_range(9))
				0, 1, 2: push_key(q, eff_len);
				3, 4, 5: begin
					push_key(q, eff_len);
					q.push_back(bakf_pkg::CHAR_EQUALS);
					push_word(q, $urandom_range(0, 5));
				end
				6: begin
					push_key(q, eff_len);
					do
						b = word_byte();
					while (b == bakf_pkg::CHAR_EQUALS);
					q.push_back(b);
					push_word(q, $urandom_range(0, 3));
				end
				7: push_key(q, $urandom_range(0, eff_len));
				8: push_word(q, $urandom_range(1, 6));
				default: repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(255)));
			endcase
		end
		if ($urandom_range(2) == 0)
			q.push_back(DELIMS[$urandom_range(6)]);
		if (q.size() == 0)
			q.push_back(8'($urandom_range(255)));
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({found, has_value, value_offset, value_length, overflow});
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL boot_argument_key_finder_unit");
		$finish;
	end

	initial begin
		logic [7:0] line[$];
		int sent;
		sb = new();
		arst_n <= 1'b0;
		cfg_write_enable <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		text_byte <= '0;
		final_byte <= 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed lines: flags, values, prefixes, empty values and edge bytes.
		key_chars[0] = 8'h61;
		key_chars[1] = 8'h62;
		apply_key(2);
		send_text("ab");
		send_text("ab=xy ab");
		send_text("abc ab=");
		line = {8'h00, 8'h61, 8'h62, bakf_pkg::CHAR_EQUALS, 8'h31, 8'h09};
		send_line(line);
		line = {8'hFF};
		send_line(line);
		wait_idle();
		apply_key(0);
		send_text("=v x");

		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 16 : (p == 1) ? 85 : 0;
			recv_idle_pct = (p == 0) ? 85 : (p == 1) ? 16 : 0;
			for (int s = 0; s < KEYS_PER_PHASE; s++) begin
				wait_idle();
				load_key(p * KEYS_PER_PHASE + s);
				sent = 0;
				while (sent < BYTES_PER_KEY) begin
					build_line(line);
					send_line(line);
					sent += line.size();
				end
			end
		end

		wait_idle();
		if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
			$display("PASS boot_argument_key_finder_unit");
		else
			$display("FAIL boot_argument_key_finder_unit");
		$finish;
	end

endmodule
